// ===== design/snss_pkg.sv =====
// Shared constants, types and glyph helpers of the signed seven-segment unit.
package snss_pkg;

	localparam int VALUE_W     = 16;
	localparam int DIGIT_COUNT = 4;
	// Five decimal digits hold any 16-bit magnitude, including 32768.
	localparam int BCD_DIGITS  = 5;
	localparam int BCD_W       = BCD_DIGITS * 4;
	localparam int CNT_W       = $clog2(VALUE_W + 1);
	localparam int POS_W       = $clog2(DIGIT_COUNT + 1);
	localparam int EN_W        = 4;
	localparam int SEG_W       = 8;

	localparam logic [SEG_W-1:0] SEG_A = 8'h08;
	localparam logic [SEG_W-1:0] SEG_B = 8'h20;
	localparam logic [SEG_W-1:0] SEG_C = 8'h80;
	localparam logic [SEG_W-1:0] SEG_D = 8'h02;
	localparam logic [SEG_W-1:0] SEG_E = 8'h01;
	localparam logic [SEG_W-1:0] SEG_F = 8'h10;
	localparam logic [SEG_W-1:0] SEG_G = 8'h40;

	typedef logic [BCD_W-1:0] bcd_t;

	typedef enum logic {
		ST_IDLE,
		ST_CONVERT
	} top_state_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_DIGITS,
		GEN_MINUS,
		GEN_DASH
	} gen_mode_t;

	typedef struct packed {
		logic load;
		logic neg;
		logic too_large;
		bcd_t bcd;
	} gen_load_t;

	// Segment pattern of one decimal digit.
	function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			4'd1:    s = SEG_B | SEG_C;
			4'd2:    s = SEG_A | SEG_B | SEG_G | SEG_D | SEG_E;
			4'd3:    s = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
			4'd4:    s = SEG_B | SEG_C | SEG_F | SEG_G;
			4'd5:    s = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
			4'd6:    s = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			4'd7:    s = SEG_A | SEG_B | SEG_C;
			4'd8:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			4'd9:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
			default: s = '0;
		endcase
		return s;
	endfunction

	// Active-low enable for a 1-based digit position; position zero drives all digits.
	function automatic logic [EN_W-1:0] enable_for(input logic [POS_W-1:0] pos);
		logic [EN_W-1:0] en;
		for (int b = 0; b < EN_W; b++) begin
			en[b] = (pos != '0) && (int'(pos) != b + 1);
		end
		return en;
	endfunction

endpackage

// ===== design/snss_bin2bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-three), one bit per cycle.
module snss_bin2bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [snss_pkg::VALUE_W-1:0] mag,
	output logic                        busy,
	output snss_pkg::bcd_t              bcd
);

	logic [snss_pkg::CNT_W-1:0]   cnt_q;
	logic [snss_pkg::VALUE_W-1:0] bin_q;
	snss_pkg::bcd_t               bcd_q;
	snss_pkg::bcd_t               adj;

	// Each digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < snss_pkg::BCD_DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                          : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= snss_pkg::CNT_W'(snss_pkg::VALUE_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[snss_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[snss_pkg::BCD_W-2:0], bin_q[snss_pkg::VALUE_W-1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

endmodule

// ===== design/snss_frame_gen.sv =====
// Frame generator: shifts BCD digits out one per frame into the output register, plus minus and dash frames.
module snss_frame_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  snss_pkg::gen_load_t           ld,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [snss_pkg::EN_W-1:0]     digit_enable_n,
	output logic [snss_pkg::SEG_W-1:0]    segments,
	output logic                          last
);

	snss_pkg::gen_mode_t           mode_q, mode_d;
	snss_pkg::bcd_t                dig_q;
	snss_pkg::bcd_t                rest;
	logic [snss_pkg::POS_W-1:0]    pos_q;
	logic                          neg_q;
	logic                          advance;
	logic                          out_valid_q;
	logic [snss_pkg::EN_W-1:0]     en_d, en_q;
	logic [snss_pkg::SEG_W-1:0]    seg_d, seg_q;
	logic                          last_d, last_q;

	assign rest    = dig_q >> 4;
	assign advance = (mode_q != snss_pkg::GEN_IDLE) && (!out_valid_q || !out_stall);

	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			snss_pkg::GEN_IDLE: begin
				if (ld.load) begin
					mode_d = ld.too_large ? snss_pkg::GEN_DASH : snss_pkg::GEN_DIGITS;
				end
			end
			snss_pkg::GEN_DIGITS: begin
				if (advance && rest == '0) begin
					mode_d = neg_q ? snss_pkg::GEN_MINUS : snss_pkg::GEN_IDLE;
				end
			end
			snss_pkg::GEN_MINUS,
			snss_pkg::GEN_DASH: begin
				if (advance) begin
					mode_d = snss_pkg::GEN_IDLE;
				end
			end
			default: mode_d = snss_pkg::GEN_IDLE;
		endcase
	end

	always_comb begin
		en_d   = snss_pkg::enable_for(pos_q);
		seg_d  = snss_pkg::SEG_G;
		last_d = 1'b1;
		case (mode_q)
			snss_pkg::GEN_DIGITS: begin
				seg_d  = snss_pkg::glyph(dig_q[3:0]);
				last_d = (rest == '0) && !neg_q;
			end
			snss_pkg::GEN_DASH: begin
				en_d = snss_pkg::enable_for(snss_pkg::POS_W'(snss_pkg::DIGIT_COUNT));
			end
			default: begin
				seg_d = snss_pkg::SEG_G;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= snss_pkg::GEN_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mode_q == snss_pkg::GEN_IDLE && ld.load) begin
			dig_q <= ld.bcd;
			neg_q <= ld.neg;
			pos_q <= snss_pkg::POS_W'(snss_pkg::DIGIT_COUNT);
		end else if (advance && mode_q == snss_pkg::GEN_DIGITS) begin
			dig_q <= rest;
			pos_q <= pos_q - 1'b1;
		end
		if (advance) begin
			en_q   <= en_d;
			seg_q  <= seg_d;
			last_q <= last_d;
		end
	end

	assign busy           = (mode_q != snss_pkg::GEN_IDLE);
	assign out_valid      = out_valid_q;
	assign digit_enable_n = en_q;
	assign segments       = seg_q;
	assign last           = last_q;

endmodule

// ===== design/signed_number_to_seven_segment_unit.sv =====
// Top level: signed 16-bit number to multiplexed seven-segment display frames.
//
//   Channel  Direction  Handshake           Payload
//   in       request in  in_valid/in_stall   value (16-bit signed)
//   out      frame out   out_valid/out_stall digit_enable_n, segments, last
//
// After accepting a request the block stalls its input while the bit-serial BCD
// converter runs its sixteen shift steps, until the digits are handed to the frame
// generator once it is idle. Frames then leave at one per cycle unless stalled
// (one to five) while the next request is already being converted.
// Reset (arst_n low) empties the converter, the generator and the output register.
// A stalled output holds its frame; the generator and then the input wait behind it.
module signed_number_to_seven_segment_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [snss_pkg::VALUE_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [snss_pkg::EN_W-1:0]       digit_enable_n,
	output logic [snss_pkg::SEG_W-1:0]      segments,
	output logic                            last
);

	snss_pkg::top_state_t         state_q, state_d;
	logic                         accept;
	logic                         neg_q;
	logic [snss_pkg::VALUE_W-1:0] mag;
	logic                         conv_busy;
	snss_pkg::bcd_t               bcd;
	logic                         too_large;
	logic                         gen_busy;
	snss_pkg::gen_load_t          ld;

	assign accept = in_valid && !in_stall;

	// Two's complement negation; -32768 maps to 32768, which fits unsigned.
	assign mag = value[snss_pkg::VALUE_W-1] ? snss_pkg::VALUE_W'(-value)
	                                        : snss_pkg::VALUE_W'(value);

	// A nonzero digit at or above the display width means the number cannot be shown.
	always_comb begin
		too_large = 1'b0;
		for (int i = 0; i < snss_pkg::BCD_DIGITS; i++) begin
			if (i >= snss_pkg::DIGIT_COUNT && bcd[i*4 +: 4] != 4'd0) begin
				too_large = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			snss_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = snss_pkg::ST_CONVERT;
				end
			end
			snss_pkg::ST_CONVERT: begin
				// A zero value produces no frames and simply returns to idle.
				if (!conv_busy && (bcd == '0 || !gen_busy)) begin
					state_d = snss_pkg::ST_IDLE;
				end
			end
			default: state_d = snss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != snss_pkg::ST_IDLE);
		ld.load      = (state_q == snss_pkg::ST_CONVERT) && !conv_busy && (bcd != '0)
		               && !gen_busy;
		ld.neg       = neg_q;
		ld.too_large = too_large;
		ld.bcd       = bcd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value[snss_pkg::VALUE_W-1];
		end
	end

	snss_bin2bcd u_bin2bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.busy   (conv_busy),
		.bcd    (bcd)
	);

	snss_frame_gen u_frame_gen (
		.clk            (clk),
		.arst_n         (arst_n),
		.ld             (ld),
		.busy           (gen_busy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_enable_n (digit_enable_n),
		.segments       (segments),
		.last           (last)
	);

endmodule

// ===== bench/tb_signed_number_to_seven_segment_unit.sv =====
// Testbench of the signed number to seven-segment frame unit, with its own frame predictor.
`timescale 1ns / 1ps

module tb_signed_number_to_seven_segment_unit;

	// Widths and segment pins as the block defines them.
	localparam int VALUE_W     = snss_pkg::VALUE_W;
	localparam int DIGIT_COUNT = snss_pkg::DIGIT_COUNT;
	localparam int EN_W        = snss_pkg::EN_W;
	localparam int SEG_W       = snss_pkg::SEG_W;

	localparam logic [SEG_W-1:0] SEG_A = snss_pkg::SEG_A;
	localparam logic [SEG_W-1:0] SEG_B = snss_pkg::SEG_B;
	localparam logic [SEG_W-1:0] SEG_C = snss_pkg::SEG_C;
	localparam logic [SEG_W-1:0] SEG_D = snss_pkg::SEG_D;
	localparam logic [SEG_W-1:0] SEG_E = snss_pkg::SEG_E;
	localparam logic [SEG_W-1:0] SEG_F = snss_pkg::SEG_F;
	localparam logic [SEG_W-1:0] SEG_G = snss_pkg::SEG_G;

	// Cycles without any accepted request or frame before the run is declared hung.
	// This covers the long output hold below several times over.
	localparam int IDLE_LIMIT   = 2000;
	// Cycles allowed after the last expected frame. A request of zero makes no
	// frames but still runs through the converter.
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 250;
	localparam int MAX_IDLE     = 14;
	localparam int MAX_REPORTS  = 10;

	// Segment patterns of the ten decimal digits, built from the package pin constants.
	localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
		SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F,
		SEG_B | SEG_C,
		SEG_A | SEG_B | SEG_G | SEG_D | SEG_E,
		SEG_A | SEG_B | SEG_G | SEG_C | SEG_D,
		SEG_B | SEG_C | SEG_F | SEG_G,
		SEG_A | SEG_C | SEG_D | SEG_F | SEG_G,
		SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G,
		SEG_A | SEG_B | SEG_C,
		SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G,
		SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G
	};

	typedef struct packed {
		logic [EN_W-1:0]  enable_n;
		logic [SEG_W-1:0] pattern;
		logic             tail;
	} frame_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [EN_W-1:0]            digit_enable_n;
	logic [SEG_W-1:0]           segments;
	logic                       last;

	// Frames the display should show, oldest first.
	frame_t expected_frames[$];

	// Current idling limits of the two sides; a limit of zero gives a stretch
	// with no idling at all.
	int in_gap_max = MAX_IDLE;
	int out_stall_max = MAX_IDLE;
	// Set by a test to make the display side hold off for a long stretch.
	int hold_request = 0;

	int errors = 0;
	int numbers_sent = 0;
	int zero_count = 0;
	int negative_count = 0;
	int overflow_count = 0;
	int frames_checked = 0;
	int idle_cycles = 0;

	signed_number_to_seven_segment_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_enable_n (digit_enable_n),
		.segments       (segments),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Active-low enable word that selects one 1-based digit. Position zero means
	// the minus sign had no free digit left, so every digit is switched on.
	function automatic logic [EN_W-1:0] enable_pattern(input int pos);
		if (pos == 0) begin
			return '0;
		end
		return ~(EN_W'(1) << (pos - 1));
	endfunction

	// Works out the frames of one accepted number and queues them. Digits go
	// out least significant first, from the rightmost digit leftward, and a
	// negative number closes with a minus sign one digit further left.
	function automatic void predict_frames(input logic signed [VALUE_W-1:0] number);
		int     magnitude;
		int     capacity;
		int     pos;
		logic   negative;
		frame_t f;
		negative = number[VALUE_W-1];
		magnitude = negative ? -int'(number) : int'(number);
		capacity = 1;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			capacity *= 10;
		end
		numbers_sent++;
		if (negative) begin
			negative_count++;
		end
		// A zero makes no frames at all.
		if (magnitude == 0) begin
			zero_count++;
			return;
		end
		// Anything that does not fit, including the most negative number,
		// shows a single dash on the rightmost digit.
		if (magnitude >= capacity) begin
			overflow_count++;
			f = '{enable_n: enable_pattern(DIGIT_COUNT), pattern: SEG_G, tail: 1'b1};
			expected_frames.push_back(f);
			return;
		end
		pos = DIGIT_COUNT;
		while (magnitude > 0) begin
			f.enable_n = enable_pattern(pos);
			f.pattern = DIGIT_GLYPH[magnitude % 10];
			f.tail = (magnitude < 10) && !negative;
			expected_frames.push_back(f);
			magnitude /= 10;
			pos--;
		end
		if (negative) begin
			f = '{enable_n: enable_pattern(pos), pattern: SEG_G, tail: 1'b1};
			expected_frames.push_back(f);
		end
	endfunction

	// Random number biased toward magnitudes that fit on the display, so that
	// most requests produce full digit runs. A share of raw 16-bit words makes
	// sure every input bit is seen at both values.
	function automatic logic signed [VALUE_W-1:0] random_number();
		int magnitude;
		case ($urandom_range(0, 9))
			0: return VALUE_W'($urandom);
			1: return '0;
			2: magnitude = $urandom_range(1, 9);
			3: magnitude = $urandom_range(10, 99);
			4: magnitude = $urandom_range(100, 999);
			5: magnitude = $urandom_range(10000, 32767);
			default: magnitude = $urandom_range(1000, 9999);
		endcase
		if ($urandom_range(0, 1) == 1) begin
			magnitude = -magnitude;
		end
		return magnitude[VALUE_W-1:0];
	endfunction

	// Offers one request after a random gap and waits until it is taken. The
	// task is entered and left at a rising edge, so valid gets at most one
	// update per edge even when requests follow back to back.
	task automatic send_number(input logic signed [VALUE_W-1:0] number);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= number;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_frames(number);
	endtask

	// Extremes of the range, every digit glyph, inner zeros, the minus sign on
	// a free digit and with all digits used, and the out-of-range dash.
	task automatic test_directed_values();
		logic signed [VALUE_W-1:0] numbers [$];
		numbers = '{16'sd0, 16'sd1, -16'sd1, 16'sd9, -16'sd9, 16'sd10, -16'sd10,
			16'sd90, 16'sd1234, 16'sd5678, -16'sd4321, 16'sd9999, -16'sd9999,
			-16'sd999, 16'sd1000, -16'sd1000, 16'sd100, 16'sd10000, -16'sd10000,
			16'sd32767, -16'sd32768, -16'sd21846};
		foreach (numbers[i]) begin
			send_number(numbers[i]);
		end
	endtask

	// Random numbers: first a stretch at full rate on both sides, then with
	// random gaps from the source and random stalls from the display side.
	task automatic test_random_numbers();
		in_gap_max = 0;
		out_stall_max = 0;
		repeat (60) send_number(random_number());
		in_gap_max = MAX_IDLE;
		out_stall_max = MAX_IDLE;
		repeat (124) send_number(random_number());
	endtask

	// The display side holds off for a long stretch while requests keep coming,
	// so the frame generator and converter fill and the input stalls.
	task automatic test_output_backpressure();
		in_gap_max = 0;
		hold_request = HOLD_CYCLES;
		repeat (14) send_number(random_number());
		in_gap_max = MAX_IDLE;
	endtask

	// Display side: stalls a random number of cycles before each frame, and
	// serves a long hold when a test asks for one.
	initial begin
		int stall_len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end
			stall_len = $urandom_range(0, out_stall_max);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) begin
				@(posedge clk);
			end
		end
	end

	// Compares every frame the display takes with the oldest expected one.
	always @(posedge clk) begin : frame_check
		frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			frames_checked++;
			if (expected_frames.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("Unexpected frame: enable_n=%b segments=%h last=%b",
						digit_enable_n, segments, last);
				end
			end else begin
				want = expected_frames.pop_front();
				if (digit_enable_n !== want.enable_n || segments !== want.pattern ||
						last !== want.tail) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("Frame mismatch: expected %b/%h/%b, got %b/%h/%b",
							want.enable_n, want.pattern, want.tail,
							digit_enable_n, segments, last);
					end
				end
			end
		end
	end

	// Hang detection: the run ends when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("Timeout: no request or frame accepted for %0d cycles", IDLE_LIMIT);
				$display("tb_signed_number_to_seven_segment_unit NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_values();
		test_random_numbers();
		test_output_backpressure();
		in_valid <= 1'b0;

		// Let the last frames drain, then give any zero request still in the
		// converter time to show that it adds nothing.
		while (expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_frames.size() != 0) begin
			errors++;
			$display("%0d expected frames never arrived", expected_frames.size());
		end

		$display("Covered %0d numbers (%0d zero, %0d negative, %0d too large), %0d frames.",
			numbers_sent, zero_count, negative_count, overflow_count, frames_checked);
		$display("Errors: %0d, including a long display hold with the input stalled.", errors);
		if (errors == 0) begin
			$display("tb_signed_number_to_seven_segment_unit OK");
		end else begin
			$display("tb_signed_number_to_seven_segment_unit NOT OK");
		end
		$finish;
	end

endmodule
